// ===== rtl/core/sat_pkg.sv =====
// Shared types and constants for the shell argument tokenizer.
package sat_pkg;

    localparam int unsigned MAX_TOKENS  = 16;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned INDEX_W     = 4;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] LIMIT_MAX   = COUNT_W'(MAX_TOKENS);
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0D;

    typedef enum logic [1:0] {
        EV_BEGIN  = 2'd0,
        EV_CHAR   = 2'd1,
        EV_END    = 2'd2,
        EV_STATUS = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_MANY = 2'd1,
        ST_UNCLOSED = 2'd2
    } line_status_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_line;
    } in_req_t;

    typedef struct packed {
        event_kind_t          event_kind;
        logic [INDEX_W-1:0]   token_index;
        logic [7:0]           token_char;
        line_status_t         line_status;
        logic [COUNT_W-1:0]   token_count;
        logic                 last_of_run;
    } out_req_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

endpackage

// ===== rtl/core/shell_argument_tokenizer.sv =====
// Top level of the shell argument tokenizer: byte-stream parser with result queue.
//
//  channel   dir  ports                   carries
//  s_        in   s_valid/s_ready/s_data  one line byte or the end-of-line marker
//  m_        out  m_valid/m_ready/m_data  token begin/char/end events, line status
//  cfg_      in   cfg_wr_en/cfg_wr_data   token_limit, written without handshake
//
// Each accepted request is parsed in the cycle it is accepted and produces up
// to two results, which go into a 4-entry result queue; m_data is the queue head.
// One request per cycle is taken while the queue has two free entries, so the
// sustained rate is one request per cycle whenever results drain as fast.
// Reset (synchronous, aresetn low) empties the queue, clears the parser and
// sets token_limit to 16. A stalled m_ready backs up into s_ready only via the queue.
module shell_argument_tokenizer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sat_pkg::in_req_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sat_pkg::out_req_t             m_data,
    input  logic                          cfg_wr_en,
    input  logic [sat_pkg::COUNT_W-1:0]   cfg_wr_data
);

    logic [sat_pkg::COUNT_W-1:0] token_limit_reg, token_limit_next;
    logic inside_token_reg, inside_token_next;
    logic quote_open_reg, quote_open_next;
    logic quote_is_double_reg, quote_is_double_next;
    logic escape_pending_reg, escape_pending_next;
    logic [sat_pkg::COUNT_W-1:0] tokens_seen_reg, tokens_seen_next;
    logic overflow_seen_reg, overflow_seen_next;

    sat_pkg::out_req_t queue_reg [sat_pkg::QUEUE_DEPTH];
    logic [sat_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sat_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sat_pkg::QCNT_W-1:0] count_reg, count_next;

    sat_pkg::out_req_t res [2];
    logic [1:0] n_res;
    logic [sat_pkg::COUNT_W-1:0] limit;
    logic [sat_pkg::INDEX_W-1:0] cur;
    logic [7:0] c;
    logic accept, pop;

    assign s_ready = count_reg <= sat_pkg::QCNT_W'(sat_pkg::QUEUE_DEPTH - 2);
    assign accept  = s_valid && s_ready;
    assign m_valid = count_reg != '0;
    assign pop     = m_valid && m_ready;
    assign m_data  = queue_reg[rd_ptr_reg];
    assign c       = s_data.char_byte;
    assign limit   = (token_limit_reg < sat_pkg::LIMIT_MAX) ? token_limit_reg
                                                            : sat_pkg::LIMIT_MAX;

    always_comb begin
        token_limit_next     = cfg_wr_en ? cfg_wr_data : token_limit_reg;
        inside_token_next    = inside_token_reg;
        quote_open_next      = quote_open_reg;
        quote_is_double_next = quote_is_double_reg;
        escape_pending_next  = escape_pending_reg;
        tokens_seen_next     = tokens_seen_reg;
        overflow_seen_next   = overflow_seen_reg;
        res[0]  = '0;
        res[1]  = '0;
        n_res   = 2'd0;
        cur     = tokens_seen_reg[sat_pkg::INDEX_W-1:0] - sat_pkg::INDEX_W'(1);

        if (accept) begin
            if (s_data.end_of_line) begin
                if (inside_token_reg && !overflow_seen_reg) begin
                    res[0].event_kind  = sat_pkg::EV_END;
                    res[0].token_index = cur;
                    n_res = 2'd1;
                end
                res[n_res[0]].event_kind  = sat_pkg::EV_STATUS;
                res[n_res[0]].token_count = tokens_seen_reg;
                if (overflow_seen_reg) begin
                    res[n_res[0]].line_status = sat_pkg::ST_TOO_MANY;
                end else if (quote_open_reg) begin
                    res[n_res[0]].line_status = sat_pkg::ST_UNCLOSED;
                end else begin
                    res[n_res[0]].line_status = sat_pkg::ST_OK;
                end
                n_res = n_res + 2'd1;
                inside_token_next    = 1'b0;
                quote_open_next      = 1'b0;
                quote_is_double_next = 1'b0;
                escape_pending_next  = 1'b0;
                tokens_seen_next     = '0;
                overflow_seen_next   = 1'b0;
            end else if (!overflow_seen_reg) begin
                if (!inside_token_reg && sat_pkg::is_blank(c)) begin
                    // blank between tokens: skipped
                end else if (!inside_token_reg && tokens_seen_reg >= limit) begin
                    overflow_seen_next = 1'b1;
                end else begin
                    if (!inside_token_reg) begin
                        cur = tokens_seen_reg[sat_pkg::INDEX_W-1:0];
                        res[0].event_kind  = sat_pkg::EV_BEGIN;
                        res[0].token_index = cur;
                        n_res = 2'd1;
                        tokens_seen_next  = tokens_seen_reg + sat_pkg::COUNT_W'(1);
                        inside_token_next = 1'b1;
                    end
                    priority if (escape_pending_reg) begin
                        escape_pending_next = 1'b0;
                        res[n_res[0]].event_kind  = sat_pkg::EV_CHAR;
                        res[n_res[0]].token_index = cur;
                        res[n_res[0]].token_char  = c;
                        n_res = n_res + 2'd1;
                    end else if (c == sat_pkg::CHAR_BACKSLASH) begin
                        escape_pending_next = 1'b1;
                    end else if (!quote_open_reg &&
                                 (c == sat_pkg::CHAR_DQUOTE || c == sat_pkg::CHAR_SQUOTE)) begin
                        quote_open_next      = 1'b1;
                        quote_is_double_next = c == sat_pkg::CHAR_DQUOTE;
                    end else if (quote_open_reg &&
                                 c == (quote_is_double_reg ? sat_pkg::CHAR_DQUOTE
                                                           : sat_pkg::CHAR_SQUOTE)) begin
                        quote_open_next      = 1'b0;
                        quote_is_double_next = 1'b0;
                    end else if (!quote_open_reg && sat_pkg::is_blank(c)) begin
                        inside_token_next = 1'b0;
                        res[n_res[0]].event_kind  = sat_pkg::EV_END;
                        res[n_res[0]].token_index = cur;
                        n_res = n_res + 2'd1;
                    end else begin
                        res[n_res[0]].event_kind  = sat_pkg::EV_CHAR;
                        res[n_res[0]].token_index = cur;
                        res[n_res[0]].token_char  = c;
                        n_res = n_res + 2'd1;
                    end
                end
            end
        end

        // n_res of 2 marks slot 1, n_res of 1 marks slot 0
        if (n_res != 2'd0) begin
            res[n_res[1]].last_of_run = 1'b1;
        end

        wr_ptr_next = wr_ptr_reg + sat_pkg::QPTR_W'(n_res);
        rd_ptr_next = rd_ptr_reg + sat_pkg::QPTR_W'(pop);
        count_next  = count_reg + sat_pkg::QCNT_W'(n_res) - sat_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_limit_reg     <= sat_pkg::LIMIT_RESET;
            inside_token_reg    <= 1'b0;
            quote_open_reg      <= 1'b0;
            quote_is_double_reg <= 1'b0;
            escape_pending_reg  <= 1'b0;
            tokens_seen_reg     <= '0;
            overflow_seen_reg   <= 1'b0;
            wr_ptr_reg          <= '0;
            rd_ptr_reg          <= '0;
            count_reg           <= '0;
        end else begin
            token_limit_reg     <= token_limit_next;
            inside_token_reg    <= inside_token_next;
            quote_open_reg      <= quote_open_next;
            quote_is_double_reg <= quote_is_double_next;
            escape_pending_reg  <= escape_pending_next;
            tokens_seen_reg     <= tokens_seen_next;
            overflow_seen_reg   <= overflow_seen_next;
            wr_ptr_reg          <= wr_ptr_next;
            rd_ptr_reg          <= rd_ptr_next;
            count_reg           <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_res != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res[0];
        end
        if (n_res == 2'd2) begin
            queue_reg[wr_ptr_reg + sat_pkg::QPTR_W'(1)] <= res[1];
        end
    end

endmodule

// ===== rtl/core/sat_checker.sv =====
// Port-level assertions for the shell argument tokenizer, bound to the top level.
module sat_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input sat_pkg::out_req_t   m_data
);

    // a stalled result request holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result request changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind != sat_pkg::EV_CHAR |-> m_data.token_char == '0)
        else $error("token_char set outside a character event");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == sat_pkg::EV_STATUS
            |-> m_data.last_of_run && m_data.token_index == '0)
        else $error("line status not last or has a token index");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind != sat_pkg::EV_STATUS
            |-> m_data.line_status == sat_pkg::ST_OK && m_data.token_count == '0)
        else $error("status fields set on a token event");

endmodule

bind shell_argument_tokenizer sat_checker u_sat_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
